FILE: src/stuffed_frame_builder_assert.svh
// Assertion macros shared by the stuffed frame builder RTL.
`ifndef STUFFED_FRAME_BUILDER_ASSERT_SVH
`define STUFFED_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define SFB_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfb: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define SFB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfb: next-cycle check failed");

`endif

FILE: src/sfb_pkg.sv
// Shared types and constants of the stuffed frame builder.
package sfb_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 16;
    localparam int MAX_OUT   = 7;
    localparam int OUT_W     = MAX_OUT * BYTE_W;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FLAG,
        REG_TAIL_FLAG,
        REG_MAP_FLAG,
        REG_STUFF_LOW,
        REG_STUFF_HIGH,
        REG_CHECK_MODE
    } t_reg_idx;

    localparam logic [BYTE_W-1:0] HEADER_FLAG_RST = 8'd126;
    localparam logic [BYTE_W-1:0] TAIL_FLAG_RST   = 8'd127;
    localparam logic [BYTE_W-1:0] MAP_FLAG_RST    = 8'd125;
    localparam logic [BYTE_W-1:0] STUFF_LOW_RST   = 8'd125;
    localparam logic [BYTE_W-1:0] STUFF_HIGH_RST  = 8'd127;
    localparam logic              CHECK_MODE_RST  = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] header_flag;
        logic [BYTE_W-1:0] tail_flag;
        logic [BYTE_W-1:0] map_flag;
        logic [BYTE_W-1:0] stuff_low;
        logic [BYTE_W-1:0] stuff_high;
        logic              check_mode;
    } t_cfg;

    typedef struct packed {
        logic              mid_frame;
        logic [BYTE_W-1:0] xor_acc;
        logic [SUM_W-1:0]  sum_acc;
    } t_acc;

    // Output bytes of one item, first byte in the low bits.
    typedef struct packed {
        logic [OUT_W-1:0] bytes;
        logic [CNT_W-1:0] len;
        logic             ends_frame;
    } t_expand;

endpackage

FILE: src/sfb_channels.sv
// Handshake channel interfaces of the stuffed frame builder.
interface sfb_in_if;
    logic                      valid;
    logic                      ready;
    logic [sfb_pkg::BYTE_W-1:0] payload_byte;
    logic                      frame_last;

    modport source (output valid, output payload_byte, output frame_last, input ready);
    modport sink   (input valid, input payload_byte, input frame_last, output ready);
endinterface

interface sfb_out_if;
    logic                      valid;
    logic                      ready;
    logic [sfb_pkg::BYTE_W-1:0] line_byte;
    logic                      frame_done;

    modport source (output valid, output line_byte, output frame_done, input ready);
    modport sink   (input valid, input line_byte, input frame_done, output ready);
endinterface

interface sfb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sfb_pkg::CFG_IDX_W-1:0] index;
    logic [sfb_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/sfb_expand.sv
// Combinational expansion of one payload byte into its stuffed output bytes.
module sfb_expand (
    input  sfb_pkg::t_cfg              i_cfg,
    input  sfb_pkg::t_acc              i_acc,
    input  logic [sfb_pkg::BYTE_W-1:0] i_payload_byte,
    input  logic                       i_frame_last,
    output sfb_pkg::t_expand           o_exp,
    output sfb_pkg::t_acc              o_acc
);
    import sfb_pkg::*;

    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] first;
    } t_seg;

    function automatic t_seg stuff(input logic [BYTE_W-1:0] b, input t_cfg c);
        t_seg s;
        s.two    = (b >= c.stuff_low) && (b <= c.stuff_high);
        s.first  = s.two ? c.map_flag : b;
        s.second = s.two ? BYTE_W'(b - c.map_flag) : '0;
        return s;
    endfunction

    t_seg              lead_seg;
    t_seg              chk0_seg;
    t_seg              chk1_seg;
    logic [BYTE_W-1:0] n_xor;
    logic [SUM_W-1:0]  n_sum;
    logic [OUT_W-1:0]  bytes;
    logic [CNT_W-1:0]  pos;

    always_comb begin
        if (!i_acc.mid_frame) begin
            lead_seg.two    = 1'b1;
            lead_seg.first  = i_cfg.header_flag;
            lead_seg.second = i_payload_byte;
            n_xor           = i_payload_byte;
            n_sum           = SUM_W'(i_payload_byte);
        end else begin
            lead_seg = stuff(i_payload_byte, i_cfg);
            n_xor    = i_acc.xor_acc ^ i_payload_byte;
            n_sum    = i_acc.sum_acc + SUM_W'(i_payload_byte);
        end

        chk0_seg = stuff(i_cfg.check_mode ? n_sum[BYTE_W-1:0] : n_xor, i_cfg);
        chk1_seg = stuff(n_sum[SUM_W-1:BYTE_W], i_cfg);

        // Segments are appended at the running byte position.
        bytes = OUT_W'({lead_seg.second, lead_seg.first});
        pos   = lead_seg.two ? CNT_W'(2) : CNT_W'(1);
        if (i_frame_last) begin
            bytes = bytes | (OUT_W'({chk0_seg.second, chk0_seg.first}) << {pos, 3'b000});
            pos   = pos + (chk0_seg.two ? CNT_W'(2) : CNT_W'(1));
            if (i_cfg.check_mode) begin
                bytes = bytes | (OUT_W'({chk1_seg.second, chk1_seg.first}) << {pos, 3'b000});
                pos   = pos + (chk1_seg.two ? CNT_W'(2) : CNT_W'(1));
            end
            bytes = bytes | (OUT_W'(i_cfg.tail_flag) << {pos, 3'b000});
            pos   = pos + CNT_W'(1);
        end

        o_exp.bytes      = bytes;
        o_exp.len        = pos;
        o_exp.ends_frame = i_frame_last;

        if (i_frame_last) begin
            o_acc = '0;
        end else begin
            o_acc.mid_frame = 1'b1;
            o_acc.xor_acc   = n_xor;
            o_acc.sum_acc   = n_sum;
        end
    end

endmodule

FILE: src/stuffed_frame_builder.sv
// Stuffed frame builder top level: byte-stuffing framer with XOR or sum check.
// Usage:
//   i_in_ch carries payload bytes; the first byte of a frame is the command, and
//   frame_last marks the final byte. o_out_ch delivers the line bytes one per
//   item, with frame_done set on the tail flag. i_cfg_ch writes the six
//   registers (header, tail, map flag, stuff low/high, check mode); it is always
//   ready and should be used only while no frame byte is still in flight.
//   Each accepted item is expanded in the accept cycle into 1 to 7 line bytes
//   held in an output buffer; the first of them is offered the next cycle.
//   An item occupies the output until each byte it yields has gone out: 1 or 2
//   for a data byte, 2 to 7 when it opens or closes a frame. The next item is
//   taken in the same cycle the last buffered byte leaves, so there is no gap.
//   Reset restores the register defaults and starts waiting for a command byte.
//   When the receiver stalls, the buffered byte holds and the input is not
//   ready until the buffer is down to its last byte being taken.
module stuffed_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfb_in_if.sink      i_in_ch,
    sfb_out_if.source   o_out_ch,
    sfb_cfg_if.sink     i_cfg_ch
);
    import sfb_pkg::*;

    `include "stuffed_frame_builder_assert.svh"

    t_cfg             r_cfg;
    t_acc             r_acc;
    t_acc             n_acc;
    t_expand          n_exp;
    logic [OUT_W-1:0] r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_tail;
    logic             in_accept;
    logic             out_pop;

    sfb_expand u_expand (
        .i_cfg          (r_cfg),
        .i_acc          (r_acc),
        .i_payload_byte (i_in_ch.payload_byte),
        .i_frame_last   (i_in_ch.frame_last),
        .o_exp          (n_exp),
        .o_acc          (n_acc)
    );

    assign out_pop   = o_out_ch.valid && o_out_ch.ready;
    assign in_accept = i_in_ch.valid && i_in_ch.ready;

    assign i_in_ch.ready       = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_out_ch.ready);
    assign i_cfg_ch.ready      = 1'b1;
    assign o_out_ch.valid      = (r_cnt != '0);
    assign o_out_ch.line_byte  = r_buf[BYTE_W-1:0];
    assign o_out_ch.frame_done = r_tail && (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_flag <= HEADER_FLAG_RST;
            r_cfg.tail_flag   <= TAIL_FLAG_RST;
            r_cfg.map_flag    <= MAP_FLAG_RST;
            r_cfg.stuff_low   <= STUFF_LOW_RST;
            r_cfg.stuff_high  <= STUFF_HIGH_RST;
            r_cfg.check_mode  <= CHECK_MODE_RST;
            r_acc             <= '0;
            r_cnt             <= '0;
            r_tail            <= 1'b0;
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                unique case (i_cfg_ch.index)
                    REG_HEADER_FLAG: r_cfg.header_flag <= i_cfg_ch.data;
                    REG_TAIL_FLAG:   r_cfg.tail_flag   <= i_cfg_ch.data;
                    REG_MAP_FLAG:    r_cfg.map_flag    <= i_cfg_ch.data;
                    REG_STUFF_LOW:   r_cfg.stuff_low   <= i_cfg_ch.data;
                    REG_STUFF_HIGH:  r_cfg.stuff_high  <= i_cfg_ch.data;
                    REG_CHECK_MODE:  r_cfg.check_mode  <= i_cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_buf  <= n_exp.bytes;
                r_cnt  <= n_exp.len;
                r_tail <= n_exp.ends_frame;
                r_acc  <= n_acc;
            end else if (out_pop) begin
                r_buf <= r_buf >> BYTE_W;
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `SFB_ASSERT_SAME(a_ready_buf_low, i_clk, i_rst_n, i_in_ch.ready, r_cnt <= CNT_W'(1))
    `SFB_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_accept, r_cnt != '0)
    `SFB_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, in_accept && i_in_ch.frame_last, !r_acc.mid_frame)
    `SFB_ASSERT_NEXT(a_data_opens, i_clk, i_rst_n, in_accept && !i_in_ch.frame_last, r_acc.mid_frame)
    `SFB_ASSERT_NEXT(a_pop_counts, i_clk, i_rst_n, out_pop && !in_accept, r_cnt == CNT_W'($past(r_cnt) - CNT_W'(1)))

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the stuffed frame builder with its own framing predictor.
module tb;
    import sfb_pkg::*;

    // First register index past the end of the register list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] IDX_PAST_LAST = CFG_IDX_W'(REG_CHECK_MODE) + 1'b1;

    typedef struct {
        logic [BYTE_W-1:0] line_byte;
        logic              frame_done;
    } t_line_item;

    logic i_clk;
    logic i_rst_n;

    sfb_in_if  in_ch();
    sfb_out_if out_ch();
    sfb_cfg_if cfg_ch();

    stuffed_frame_builder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    t_line_item expected_line[$];
    t_cfg       cfg_model;
    t_acc       frame_acc;
    int         err_count = 0;
    bit         idling_on = 1'b1;
    int         hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_line(logic [BYTE_W-1:0] b, logic done);
        t_line_item item;
        item.line_byte  = b;
        item.frame_done = done;
        expected_line.push_back(item);
    endfunction

    function automatic void push_stuffed(logic [BYTE_W-1:0] b);
        if (b >= cfg_model.stuff_low && b <= cfg_model.stuff_high) begin
            push_line(cfg_model.map_flag, 1'b0);
            push_line(BYTE_W'(b - cfg_model.map_flag), 1'b0);
        end else begin
            push_line(b, 1'b0);
        end
    endfunction

    function automatic void predict_frame_bytes(logic [BYTE_W-1:0] b, logic last);
        if (!frame_acc.mid_frame) begin
            // The command byte goes out raw right after the header flag.
            push_line(cfg_model.header_flag, 1'b0);
            push_line(b, 1'b0);
            frame_acc.xor_acc   = b;
            frame_acc.sum_acc   = SUM_W'(b);
            frame_acc.mid_frame = 1'b1;
        end else begin
            push_stuffed(b);
            frame_acc.xor_acc = frame_acc.xor_acc ^ b;
            frame_acc.sum_acc = frame_acc.sum_acc + SUM_W'(b);
        end
        if (last) begin
            if (!cfg_model.check_mode) begin
                push_stuffed(frame_acc.xor_acc);
            end else begin
                push_stuffed(frame_acc.sum_acc[BYTE_W-1:0]);
                push_stuffed(frame_acc.sum_acc[SUM_W-1:BYTE_W]);
            end
            push_line(cfg_model.tail_flag, 1'b1);
            frame_acc = '0;
        end
    endfunction

    // ---------------------------------------------------------------- result checker

    always @(posedge i_clk) begin
        t_line_item item;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_line.size() == 0) begin
                $error("unexpected line byte %02h (frame_done %0b)", out_ch.line_byte,
                       out_ch.frame_done);
                err_count++;
            end else begin
                item = expected_line.pop_front();
                if (out_ch.line_byte !== item.line_byte) begin
                    $error("line_byte mismatch: expected %02h, actual %02h",
                           item.line_byte, out_ch.line_byte);
                    err_count++;
                end
                if (out_ch.frame_done !== item.frame_done) begin
                    $error("frame_done mismatch: expected %0b, actual %0b",
                           item.frame_done, out_ch.frame_done);
                    err_count++;
                end
            end
        end
    end

    // The receiver stalls in random bursts, or for one long hold when asked.
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Leaves valid high after the accept so a following item goes out back to back.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= b;
        in_ch.frame_last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_frame_bytes(b, last);
    endtask

    task automatic drain_output();
        in_ch.valid <= 1'b0;
        while (expected_line.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_HEADER_FLAG: cfg_model.header_flag = data;
            REG_TAIL_FLAG:   cfg_model.tail_flag   = data;
            REG_MAP_FLAG:    cfg_model.map_flag    = data;
            REG_STUFF_LOW:   cfg_model.stuff_low   = data;
            REG_STUFF_HIGH:  cfg_model.stuff_high  = data;
            REG_CHECK_MODE:  cfg_model.check_mode  = data[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_HEADER_FLAG, c.header_flag);
        write_reg(REG_TAIL_FLAG, c.tail_flag);
        write_reg(REG_MAP_FLAG, c.map_flag);
        write_reg(REG_STUFF_LOW, c.stuff_low);
        write_reg(REG_STUFF_HIGH, c.stuff_high);
        // Only bit 0 of the mode register counts; the rest is noise.
        write_reg(REG_CHECK_MODE, {7'($urandom), c.check_mode});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        logic [BYTE_W-1:0] lo, hi;
        c.header_flag = 8'($urandom);
        c.tail_flag   = 8'($urandom);
        c.map_flag    = 8'($urandom);
        c.check_mode  = 1'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // Arbitrary bounds, often an empty range.
            c.stuff_low  = 8'($urandom);
            c.stuff_high = 8'($urandom);
        end else begin
            lo = c.header_flag;
            hi = c.header_flag;
            if (c.tail_flag < lo) lo = c.tail_flag;
            if (c.tail_flag > hi) hi = c.tail_flag;
            if (c.map_flag < lo) lo = c.map_flag;
            if (c.map_flag > hi) hi = c.map_flag;
            c.stuff_low  = lo;
            c.stuff_high = hi;
        end
        return c;
    endfunction

    // Biased toward the edges of the stuffing range, where the corner cases live.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return BYTE_W'(cfg_model.stuff_low + $urandom_range(0, 2) - 1);
            1: return BYTE_W'(cfg_model.stuff_high + $urandom_range(0, 2) - 1);
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_default_framing();
        // Reset values: the flags and their neighbors around the stuffing range.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7D, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7C, 1'b0);
        send_byte(8'h80, 1'b1);
        drain_output();
    endtask

    task automatic test_command_only();
        send_byte(8'h7E, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain_output();
    endtask

    task automatic test_sum_check();
        t_cfg c;
        c = '{header_flag: 8'h7E, tail_flag: 8'h7F, map_flag: 8'h7D,
              stuff_low: 8'h7D, stuff_high: 8'h7F, check_mode: 1'b1};
        load_config(c);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        drain_output();
    endtask

    task automatic test_no_stuff_range();
        t_cfg c;
        c = '{header_flag: 8'h10, tail_flag: 8'h11, map_flag: 8'h12,
              stuff_low: 8'd200, stuff_high: 8'd100, check_mode: 1'b0};
        load_config(c);
        send_byte(8'd150, 1'b0);
        send_byte(8'd200, 1'b0);
        send_byte(8'd100, 1'b1);
        drain_output();
    endtask

    task automatic test_extreme_flags();
        t_cfg c;
        // Every byte falls in the range, and the offset is zero.
        c = '{header_flag: 8'h00, tail_flag: 8'h00, map_flag: 8'h00,
              stuff_low: 8'h00, stuff_high: 8'hFF, check_mode: 1'b1};
        load_config(c);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain_output();
        c = '{header_flag: 8'hFF, tail_flag: 8'hFF, map_flag: 8'hFF,
              stuff_low: 8'hFF, stuff_high: 8'hFF, check_mode: 1'b0};
        load_config(c);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_output();
    endtask

    task automatic test_config_mid_frame();
        t_cfg c;
        c = '{header_flag: 8'h7E, tail_flag: 8'h7F, map_flag: 8'h7D,
              stuff_low: 8'h7D, stuff_high: 8'h7F, check_mode: 1'b0};
        load_config(c);
        send_byte(8'h10, 1'b0);
        send_byte(8'h7E, 1'b0);
        drain_output();
        // The frame stays open and keeps its running check across these writes.
        write_reg(REG_MAP_FLAG, 8'h20);
        write_reg(REG_STUFF_LOW, 8'h00);
        write_reg(REG_STUFF_HIGH, 8'h40);
        write_reg(REG_CHECK_MODE, 8'h01);
        cfg_ch.valid <= 1'b0;
        send_byte(8'h30, 1'b1);
        drain_output();
    endtask

    task automatic test_unused_register_index();
        for (int i = IDX_PAST_LAST; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 8'($urandom));
        cfg_ch.valid <= 1'b0;
        send_byte(8'h20, 1'b0);
        send_byte(8'h7D, 1'b1);
        drain_output();
    endtask

    task automatic test_backpressure();
        idling_on = 1'b0;
        load_config(random_cfg());
        hold_req = 80;
        send_frame(20);
        drain_output();
        idling_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int items;
        for (int phase = 0; phase < 3; phase++) begin
            load_config(random_cfg());
            items = 0;
            while (items < 20) begin
                int len;
                len = $urandom_range(1, 6);
                send_frame(len);
                items += len;
            end
            drain_output();
        end
    endtask

    task automatic test_quiet_tail();
        int items;
        idling_on = 1'b0;
        load_config(random_cfg());
        items = 0;
        while (items < 30) begin
            int len;
            len = $urandom_range(1, 6);
            send_frame(len);
            items += len;
        end
        drain_output();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.payload_byte <= '0;
        in_ch.frame_last   <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        cfg_model = '{header_flag: HEADER_FLAG_RST, tail_flag: TAIL_FLAG_RST,
                      map_flag: MAP_FLAG_RST, stuff_low: STUFF_LOW_RST,
                      stuff_high: STUFF_HIGH_RST, check_mode: CHECK_MODE_RST};
        frame_acc = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_framing();
        test_command_only();
        test_sum_check();
        test_no_stuff_range();
        test_extreme_flags();
        test_config_mid_frame();
        test_unused_register_index();
        test_backpressure();
        test_random_frames();
        test_quiet_tail();

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && expected_line.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
